>>> hw/rtl/blt_pkg.sv
// Shared types and codes for the thumbnail cache unit.
package blt_pkg;

  localparam int KEY_W = 64;
  localparam int HANDLE_W = 64;
  localparam int DIM_W = 16;
  localparam int BYTES_W = 34;
  localparam int CNT_W = 32;
  localparam int EVICT_W = 5;
  localparam int STATUS_W = 3;
  localparam logic [BYTES_W-1:0] BUDGET_RESET = 34'd33554432;

  localparam logic [STATUS_W-1:0] ST_ADMITTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  typedef struct packed {
    logic                action;
    logic                key_is_current;
    logic [KEY_W-1:0]    entry_key;
    logic [HANDLE_W-1:0] buffer_handle;
    logic [DIM_W-1:0]    pixel_width;
    logic [DIM_W-1:0]    pixel_height;
  } req_t;

  // request after classification by the front end
  typedef struct packed {
    logic                ignore;
    logic                find;
    logic [KEY_W-1:0]    entry_key;
    logic [HANDLE_W-1:0] buffer_handle;
    logic [DIM_W-1:0]    pixel_width;
    logic [DIM_W-1:0]    pixel_height;
    logic [BYTES_W-1:0]  item_bytes;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_handle;
    logic [DIM_W-1:0]    found_width;
    logic [DIM_W-1:0]    found_height;
    logic [EVICT_W-1:0]  evicted_now;
    logic [BYTES_W-1:0]  resident_total;
    logic [BYTES_W-1:0]  peak_total;
    logic [CNT_W-1:0]    hit_total;
    logic [CNT_W-1:0]    miss_total;
    logic [CNT_W-1:0]    eviction_total;
    logic [CNT_W-1:0]    rejection_total;
  } rsp_t;

endpackage

>>> hw/rtl/blt_front.sv
// Front end: accept request beats, compute byte size, classify.
module blt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  blt_pkg::req_t  in_req,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output blt_pkg::cmd_t  cmd
);
  import blt_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_OUT} fstate_t;

  fstate_t state;
  req_t req;
  logic [2*DIM_W-1:0] area;

  assign in_ready = (state == F_IDLE);
  assign cmd_valid = (state == F_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            req <= in_req;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          area <= req.pixel_width * req.pixel_height;
          state <= F_OUT;
        end
        F_OUT: begin
          if (cmd_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.find = req.action;
    cmd.entry_key = req.entry_key;
    cmd.buffer_handle = req.buffer_handle;
    cmd.pixel_width = req.pixel_width;
    cmd.pixel_height = req.pixel_height;
    cmd.item_bytes = {area, 2'b00};
    cmd.ignore = !req.key_is_current ||
                 (!req.action && (req.buffer_handle == '0 || area == '0));
  end

endmodule

>>> hw/rtl/blt_queue.sv
// Two-entry command queue between front and back end.
module blt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  blt_pkg::cmd_t  wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output blt_pkg::cmd_t  rd_cmd
);
  import blt_pkg::*;

  cmd_t mem [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wptr <= !wptr;
      if (rd_valid && rd_ready) rptr <= !rptr;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !wr_ready) else $error("queue accepts when full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    rd_ready && count == 2'd0 |=> count <= 2'd1) else $error("queue underflow");
`endif

endmodule

>>> hw/rtl/blt_back.sv
// Back end: slot table, lookup, eviction sequencer and counters.
module blt_back #(
  parameter int SLOTS = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [blt_pkg::BYTES_W-1:0]  cfg_data,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  blt_pkg::cmd_t                cmd_in,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output blt_pkg::rsp_t                rsp
);
  import blt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    B_IDLE, B_MATCH, B_CHECK, B_SCAN, B_EVICT, B_PLACE, B_DONE
  } bstate_t;

  bstate_t state;
  cmd_t cmd;
  logic [BYTES_W-1:0] budget;
  logic [SLOTS-1:0] slot_valid;
  logic [KEY_W-1:0] slot_key [SLOTS];
  logic [HANDLE_W-1:0] slot_handle [SLOTS];
  logic [DIM_W-1:0] slot_width [SLOTS];
  logic [DIM_W-1:0] slot_height [SLOTS];
  logic [BYTES_W-1:0] slot_bytes [SLOTS];
  logic [STAMP_BITS-1:0] slot_stamp [SLOTS];
  logic [STAMP_BITS-1:0] stamp_counter;
  logic [BYTES_W-1:0] held_bytes, peak_bytes;
  logic [CNT_W-1:0] hit_count, miss_count, eviction_count, rejection_count;
  logic [EVICT_W-1:0] evicted;
  logic match_found;
  logic [IDX_W-1:0] match_idx;
  logic [BYTES_W-1:0] match_bytes;
  logic old_found;
  logic [IDX_W-1:0] old_idx;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W:0] scan_cnt;
  logic scan_final;
  logic [STATUS_W-1:0] status;

  // combinational lookups over all SLOTS slots
  logic hit_any, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic [BYTES_W+1:0] need;

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == cmd.entry_key) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign need = {2'b00, held_bytes} + {2'b00, cmd.item_bytes} -
                {2'b00, (match_found ? match_bytes : '0)};
  assign cmd_ready = (state == B_IDLE);

  logic scan_take;
  assign scan_take = slot_valid[scan_idx] &&
                     !(scan_final && match_found && scan_idx == match_idx) &&
                     (!old_found || slot_stamp[scan_idx] < slot_stamp[old_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      budget <= BUDGET_RESET;
      slot_valid <= '0;
      stamp_counter <= '0;
      held_bytes <= '0;
      peak_bytes <= '0;
      hit_count <= '0;
      miss_count <= '0;
      eviction_count <= '0;
      rejection_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) budget <= cfg_data;
      case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            cmd <= cmd_in;
            evicted <= '0;
            state <= B_MATCH;
          end
        end
        B_MATCH: begin
          match_found <= hit_any;
          match_idx <= hit_idx;
          match_bytes <= slot_bytes[hit_idx];
          if (cmd.ignore) begin
            status <= ST_IGNORED;
            state <= B_DONE;
          end else if (cmd.find) begin
            if (hit_any && slot_handle[hit_idx] != '0) begin
              stamp_counter <= stamp_counter + 1'b1;
              slot_stamp[hit_idx] <= stamp_counter + 1'b1;
              hit_count <= hit_count + 1'b1;
              status <= ST_HIT;
            end else begin
              miss_count <= miss_count + 1'b1;
              status <= ST_MISS;
            end
            state <= B_DONE;
          end else if (cmd.item_bytes > budget) begin
            rejection_count <= rejection_count + 1'b1;
            status <= ST_REJECTED;
            state <= B_DONE;
          end else begin
            state <= B_CHECK;
          end
        end
        B_CHECK: begin
          old_found <= 1'b0;
          scan_cnt <= '0;
          if (need > {2'b00, budget}) begin
            scan_final <= 1'b1;
            scan_idx <= '0;
            state <= B_SCAN;
          end else if (match_found || free_any) begin
            state <= B_PLACE;
            scan_idx <= match_found ? match_idx : free_idx;
          end else begin
            scan_final <= 1'b0;
            scan_idx <= '0;
            state <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (scan_take) begin
            old_found <= 1'b1;
            old_idx <= scan_idx;
          end
          scan_idx <= scan_idx + 1'b1;
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == (IDX_W+1)'(SLOTS - 1)) begin
            state <= B_EVICT;
          end
        end
        B_EVICT: begin
          if (!old_found) begin
            rejection_count <= rejection_count + 1'b1;
            status <= ST_REJECTED;
            state <= B_DONE;
          end else if (scan_final) begin
            slot_valid[old_idx] <= 1'b0;
            held_bytes <= held_bytes - slot_bytes[old_idx];
            eviction_count <= eviction_count + 1'b1;
            evicted <= evicted + 1'b1;
            state <= B_CHECK;
          end else begin
            scan_idx <= old_idx;
            state <= B_PLACE;
          end
        end
        B_PLACE: begin
          // clear any occupant, then write the new entry
          if (slot_valid[scan_idx]) begin
            eviction_count <= eviction_count + 1'b1;
            evicted <= evicted + 1'b1;
          end
          begin
            logic [BYTES_W-1:0] res;
            res = held_bytes - (slot_valid[scan_idx] ? slot_bytes[scan_idx] : '0)
                  + cmd.item_bytes;
            held_bytes <= res;
            if (res > peak_bytes) peak_bytes <= res;
          end
          slot_valid[scan_idx] <= 1'b1;
          slot_key[scan_idx] <= cmd.entry_key;
          slot_handle[scan_idx] <= cmd.buffer_handle;
          slot_width[scan_idx] <= cmd.pixel_width;
          slot_height[scan_idx] <= cmd.pixel_height;
          slot_bytes[scan_idx] <= cmd.item_bytes;
          slot_stamp[scan_idx] <= stamp_counter + 1'b1;
          stamp_counter <= stamp_counter + 1'b1;
          miss_count <= miss_count + 1'b1;
          status <= ST_ADMITTED;
          state <= B_DONE;
        end
        B_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp.status <= status;
            rsp.found_handle <= (status == ST_HIT) ? slot_handle[match_idx] : '0;
            rsp.found_width <= (status == ST_HIT) ? slot_width[match_idx] : '0;
            rsp.found_height <= (status == ST_HIT) ? slot_height[match_idx] : '0;
            rsp.evicted_now <= evicted;
            rsp.resident_total <= held_bytes;
            rsp.peak_total <= peak_bytes;
            rsp.hit_total <= hit_count;
            rsp.miss_total <= miss_count;
            rsp.eviction_total <= eviction_count;
            rsp.rejection_total <= rejection_count;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (rsp_valid && rsp_ready && state != B_DONE) rsp_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_peak: assert property (@(posedge clk) disable iff (rst)
    peak_bytes >= held_bytes) else $error("peak below resident");
  a_evict_clears: assert property (@(posedge clk) disable iff (rst)
    state == B_EVICT && old_found && scan_final |=> !slot_valid[$past(old_idx)])
    else $error("evicted slot still valid");
  a_place_valid: assert property (@(posedge clk) disable iff (rst)
    state == B_PLACE |=> slot_valid[$past(scan_idx)]) else $error("placed slot invalid");
  a_evict_bound: assert property (@(posedge clk) disable iff (rst)
    evicted <= EVICT_W'(SLOTS)) else $error("too many evictions");
`endif

endmodule

>>> hw/rtl/budgeted_lru_thumbnail_cache_unit.sv
// Top level of the byte-budgeted LRU thumbnail cache.
// Usage:
//   s_axis carries one request beat: admit (action 0) or find (action 1),
//   with action and key_is_current on s_axis_tuser.
//   m_axis returns exactly one result beat per request, in order, with the
//   status on m_axis_tuser.
//   cfg_we/cfg_data write budget_bytes; write only while idle.
// Flow: the front end registers a beat, then its byte size, and the queue
//   passes it on. A find, an ignored request or one larger than the budget
//   goes through B_MATCH and B_DONE; an admit that fits goes through B_MATCH,
//   B_CHECK, B_PLACE and B_DONE. Each eviction costs one full slot scan,
//   one slot a cycle; the back end takes no request until it answers.
// A two-entry command queue lets the front accept new beats while the
//   back end works; the result register holds a beat until m_axis_tready.
// Reset (rst, synchronous) empties all slots, zeroes the counters and
//   sets the budget to 33554432 bytes.
// While the receiver stalls, the back end holds its result and stops;
//   the queue fills and then s_axis_tready drops.
module budgeted_lru_thumbnail_cache_unit #(
  parameter int SLOTS = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [33:0]   cfg_data,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // action[0], key_is_current[1]
  input  logic [1:0]    s_axis_tuser,
  // entry_key[63:0], buffer_handle[127:64], pixel_width[143:128],
  // pixel_height[159:144]
  input  logic [159:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[2:0]
  output logic [2:0]    m_axis_tuser,
  // found_handle[63:0], found_width[79:64], found_height[95:80],
  // evicted_now[100:96], resident_total[134:101], peak_total[168:135],
  // hit_total[200:169], miss_total[232:201], eviction_total[264:233],
  // rejection_total[296:265]
  output logic [303:0]  m_axis_tdata
);
  import blt_pkg::*;

  req_t req;
  cmd_t f_cmd, q_cmd;
  rsp_t rsp;
  logic f_valid, f_ready, q_valid, q_ready;

  always_comb begin
    req.action = s_axis_tuser[0];
    req.entry_key = s_axis_tdata[63:0];
    req.key_is_current = s_axis_tuser[1];
    req.buffer_handle = s_axis_tdata[127:64];
    req.pixel_width = s_axis_tdata[143:128];
    req.pixel_height = s_axis_tdata[159:144];
  end

  assign m_axis_tuser = rsp.status;
  assign m_axis_tdata = {7'b0000000, rsp.rejection_total, rsp.eviction_total,
                         rsp.miss_total, rsp.hit_total, rsp.peak_total,
                         rsp.resident_total, rsp.evicted_now, rsp.found_height,
                         rsp.found_width, rsp.found_handle};

  blt_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(req),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  blt_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd)
  );

  blt_back #(.SLOTS(SLOTS), .STAMP_BITS(STAMP_BITS)) u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_in(q_cmd),
    .rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp(rsp)
  );

endmodule
